### src/sxk_pkg.sv
package sxk_pkg;

    localparam int KEY_BYTES = 16;
    localparam int KEY_POS_W = $clog2(KEY_BYTES);

    localparam logic [31:0] SEED_MUL = 32'h9e37_79b1;
    localparam logic [63:0] GOLDEN   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] GOLDEN2  = 64'h3c6e_f372_fe94_f82a;
    localparam logic [63:0] MIX_C1   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_C2   = 64'h94d0_49bb_1331_11eb;

    // key derivation sequencer
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_BASE  = 8'b0000_0100,
        ST_MIX   = 8'b0000_1000,
        ST_MUL0  = 8'b0001_0000,
        ST_MUL1  = 8'b0010_0000,
        ST_MUL2  = 8'b0100_0000,
        ST_MUL3  = 8'b1000_0000
    } kd_state_t;

endpackage

### src/seeded_xor_keystream_top.sv
// Repeating-key XOR byte stream. A 32-bit seed is expanded into a 16-byte key
// and every byte on the input channel is XORed with the key byte at the
// current position; the same operation encrypts and decrypts.
// Channels: s_ (data_byte, last_in) in, m_ (result_byte, last_out) out, both
// valid/ready; cfg_ carries the seed, one write per transaction.
// The result is registered, shown the cycle after the input transaction.
// Throughput: one byte per cycle outside key derivation and receiver stalls;
// a new byte is taken while the previous result is being handed over, set by
// the single output register. Key derivation: after reset and after each seed
// write the key is derived on one shared 32x32 multiplier (two 64-bit
// products of three partial products each per key word); s_ready stays low
// meanwhile. A seed write keeps the key position; the position returns to zero
// after a byte marked last and wraps after 16 bytes.
// Reset loads seed zero, clears the position and the output valid flag and
// starts the derivation. When the receiver stalls, the result holds in the
// output register and s_ready drops until it is taken.
module seeded_xor_keystream_top
    import sxk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_seed,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result_byte,
    output logic        m_last_out
);

    kd_state_t              state_reg;
    logic [31:0]            seed_reg;
    logic                   word_sel_reg;
    logic                   const_sel_reg;
    logic [63:0]            prod_reg;
    logic [63:0]            acc_reg;
    logic [63:0]            v_reg;
    logic [63:0]            start_reg;
    logic [63:0]            key_word_reg [2];
    logic [KEY_POS_W-1:0]   pos_reg;
    logic                   m_valid_reg;
    logic [7:0]             result_reg;
    logic                   last_reg;

    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mix_const;
    logic [63:0]            mul_sum;
    logic [63:0]            mix_sum;
    logic [63:0]            key_word;
    logic [7:0]             key_byte;
    logic                   in_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_fire   = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_result_byte = result_reg;
    assign m_last_out    = last_reg;

    assign mix_const = const_sel_reg ? MIX_C2 : MIX_C1;
    assign mul_sum   = acc_reg + {prod_reg[31:0], 32'h0};
    assign mix_sum   = start_reg + (word_sel_reg ? GOLDEN2 : GOLDEN);

    always_comb begin
        case (state_reg)
            ST_START: begin
                mul_a = seed_reg;
                mul_b = SEED_MUL;
            end
            ST_MUL0: begin
                mul_a = v_reg[31:0];
                mul_b = mix_const[31:0];
            end
            ST_MUL1: begin
                mul_a = v_reg[31:0];
                mul_b = mix_const[63:32];
            end
            ST_MUL2: begin
                mul_a = v_reg[63:32];
                mul_b = mix_const[31:0];
            end
            default: begin
                mul_a = 32'h0;
                mul_b = 32'h0;
            end
        endcase
    end

    always_comb begin
        key_word = key_word_reg[pos_reg[KEY_POS_W-1]];
        key_byte = key_word[{pos_reg[2:0], 3'b000} +: 8];
    end

    // shared multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // key derivation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
            seed_reg  <= 32'h0;
        end else if (cfg_valid && cfg_ready) begin
            state_reg <= ST_START;
            seed_reg  <= cfg_seed;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    state_reg <= ST_IDLE;
                end
                ST_START: begin
                    state_reg <= ST_BASE;
                end
                ST_BASE: begin
                    state_reg <= ST_MIX;
                end
                ST_MIX: begin
                    state_reg <= ST_MUL0;
                end
                ST_MUL0: begin
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    state_reg <= ST_MUL3;
                end
                ST_MUL3: begin
                    if (!const_sel_reg) begin
                        state_reg <= ST_MUL0;
                    end else if (!word_sel_reg) begin
                        state_reg <= ST_MIX;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_START;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_BASE: begin
                start_reg    <= (prod_reg + 64'd1) ^ {seed_reg, 32'h0};
                word_sel_reg <= 1'b0;
            end
            ST_MIX: begin
                v_reg         <= mix_sum ^ (mix_sum >> 30);
                const_sel_reg <= 1'b0;
            end
            ST_MUL1: begin
                acc_reg <= prod_reg;
            end
            ST_MUL2: begin
                acc_reg <= mul_sum;
            end
            ST_MUL3: begin
                if (!const_sel_reg) begin
                    v_reg         <= mul_sum ^ (mul_sum >> 27);
                    const_sel_reg <= 1'b1;
                end else begin
                    key_word_reg[word_sel_reg] <= mul_sum ^ (mul_sum >> 31);
                    word_sel_reg               <= 1'b1;
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // byte path
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                m_valid_reg <= 1'b1;
                pos_reg     <= s_last_in ? '0 : KEY_POS_W'(pos_reg + 1'b1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            result_reg <= s_data_byte ^ key_byte;
            last_reg   <= s_last_in;
        end
    end

endmodule

### tb/tb_seeded_xor_keystream_checker.sv
module tb_seeded_xor_keystream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_seed,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_result_byte,
    input  logic        m_last_out,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SEED_MULT  = 64'h0000_0000_9e37_79b1;
    localparam logic [63:0] GOLDEN_INC = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] FIN_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] FIN_MUL_B  = 64'h94d0_49bb_1331_11eb;

    typedef struct packed {
        logic [7:0] cipher;
        logic       last;
    } xor_result_t;

    xor_result_t  expected_q[$];
    xor_result_t  want;
    logic [127:0] key_stream;
    logic [3:0]   key_pos;
    int           err_total;

    function automatic logic [63:0] splitmix_finalize(input logic [63:0] v);
        logic [63:0] x;
        x = v ^ (v >> 30);
        x = x * FIN_MUL_A;
        x = x ^ (x >> 27);
        x = x * FIN_MUL_B;
        return x ^ (x >> 31);
    endfunction

    // key byte i sits at bits [8*i +: 8]: word 0 low, word 1 high
    function automatic logic [127:0] expand_seed(input logic [31:0] sd);
        logic [63:0] s;
        logic [63:0] start;
        s     = {32'd0, sd};
        start = (s * SEED_MULT + 64'd1) ^ (s << 32);
        return {splitmix_finalize(start + GOLDEN_INC + GOLDEN_INC),
                splitmix_finalize(start + GOLDEN_INC)};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_stream = expand_seed(32'd0);
            key_pos    = '0;
            expected_q.delete();
            err_total  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected transaction result_byte %02h last_out %0b",
                             $time, m_result_byte, m_last_out);
                    err_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_result_byte !== want.cipher) begin
                        $display("%0t: result_byte expected %02h actual %02h",
                                 $time, want.cipher, m_result_byte);
                        err_total++;
                    end
                    if (m_last_out !== want.last) begin
                        $display("%0t: last_out expected %0b actual %0b",
                                 $time, want.last, m_last_out);
                        err_total++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want.cipher = s_data_byte ^ key_stream[key_pos*8 +: 8];
                want.last   = s_last_in;
                expected_q.push_back(want);
                key_pos = s_last_in ? 4'd0 : key_pos + 4'd1;
            end
            // position is kept across a seed change
            if (cfg_valid && cfg_ready) begin
                key_stream = expand_seed(cfg_seed);
            end
        end
        mismatches <= err_total;
        pending    <= expected_q.size();
    end

endmodule

### tb/tb_seeded_xor_keystream_top.sv
module tb_seeded_xor_keystream_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 105;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_seed;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_result_byte;
    logic        m_last_out;

    int          mismatches;
    int          pending;
    int          src_idle_pct;
    int          dst_idle_pct;
    int          cycle_count = 0;
    int          hold_req;
    int          hold_seen;

    seeded_xor_keystream_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_seed      (cfg_seed),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte),
        .m_last_out    (m_last_out)
    );

    tb_seeded_xor_keystream_checker keystream_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_seed      (cfg_seed),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte),
        .m_last_out    (m_last_out),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("seeded_xor_keystream_top: mismatch");
            $finish;
        end
    end

    // receiver side, with an occasional long hold-off
    initial begin
        m_ready   = 1'b0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_in   <= l;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_seed  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] seed_val;
        logic [7:0]  edge_byte;
        hold_req     = 0;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_seed     = '0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        s_last_in    = 1'b0;
        src_idle_pct = 15;
        dst_idle_pct = 58;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset key: run past the 16-byte wrap, then end a buffer mid-key
        for (int i = 0; i < 18; i++) begin
            edge_byte = (i[0] ? 8'hff : 8'h00) ^ (i[1] ? 8'h5a : 8'h00);
            send_byte(edge_byte, 1'b0);
        end
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        // new seed in the middle of a buffer keeps the position
        drain();
        write_seed(32'hffff_ffff);
        send_byte(8'h01, 1'b0);
        send_byte(8'hfe, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 3)
                0: begin
                    src_idle_pct = 15;
                    dst_idle_pct = 58;
                end
                1: begin
                    src_idle_pct = 58;
                    dst_idle_pct = 15;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            case (phase)
                0:       seed_val = 32'h0000_0000;
                1:       seed_val = 32'h8000_0000;
                2:       seed_val = 32'h0000_0001;
                3:       seed_val = 32'hffff_ffff;
                default: seed_val = $urandom();
            endcase
            drain();
            write_seed(seed_val);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 40 && (phase == 1 || phase == 7)) begin
                    hold_req++;
                end
                if (n == 70 && (phase % 2) == 0) begin
                    drain();
                end
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("seeded_xor_keystream_top: match");
        end else begin
            $display("seeded_xor_keystream_top: mismatch");
        end
        $finish;
    end

endmodule
